/* design/lpc_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the local peak clamp filter.
// No dependencies; the interfaces, kernel, drain and top level import this package.
package lpc_pkg;

  // Default build of the block
  localparam int unsigned MAX_WIDTH_DEF  = 1024;
  localparam int unsigned PIXEL_BITS_DEF = 16;

  // Fixed field widths
  localparam int unsigned ROW_W     = 16;
  localparam int unsigned HEIGHT_W  = 16;
  localparam int unsigned CFG_IDX_W = 1;

  // Reset value of the frame width register
  localparam int unsigned WIDTH_RST = 1024;

  // Result slots of one input pixel, in output order
  localparam int unsigned NUM_SLOTS = 3;
  localparam int unsigned SLOT_UP   = 0;  // pixel above the arriving one
  localparam int unsigned SLOT_LEFT = 1;  // last-row pixel to the left
  localparam int unsigned SLOT_SELF = 2;  // the arriving pixel (last row, last column)

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } lpc_reg_e;

  // Kernel to drain handoff control
  typedef struct packed {
    logic                 vld;
    logic [NUM_SLOTS-1:0] slots;
  } lpc_bndl_t;

endpackage

/* design/lpc_ifs.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces: pixel input and tagged result output.
// Depends on lpc_pkg.
interface lpc_pix_if import lpc_pkg::*; #(
  parameter int unsigned PIX_W = PIXEL_BITS_DEF
);
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

interface lpc_res_if import lpc_pkg::*; #(
  parameter int unsigned PIX_W = PIXEL_BITS_DEF,
  parameter int unsigned COL_W = 10
);
  logic             valid;
  logic             ready;
  logic [ROW_W-1:0] row_index;
  logic [COL_W-1:0] col_index;
  logic [PIX_W-1:0] value;
  logic             frame_done;
  logic             step_last;

  modport source (output valid, output row_index, output col_index, output value,
                  output frame_done, output step_last, input ready);
  modport sink   (input valid, input row_index, input col_index, input value,
                  input frame_done, input step_last, output ready);
endinterface

/* design/lpc_ram.sv */
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing; read returns the old word on a same-address write.
module lpc_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* design/lpc_kernel.sv */
`timescale 1ns / 1ps
// Clamp kernel: config registers, raster counters, row memories with forwarding,
// and the three neighbor-max clamps. Depends on lpc_pkg and lpc_ram.
module lpc_kernel import lpc_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int unsigned PIXEL_BITS = PIXEL_BITS_DEF,
  localparam int unsigned COL_W     = $clog2(MAX_WIDTH),
  localparam int unsigned WREG_W    = COL_W + 1,
  localparam int unsigned CFG_W     = (WREG_W > HEIGHT_W) ? WREG_W : HEIGHT_W
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]                  cfg_idx_i,
  input  logic [CFG_W-1:0]                      cfg_wdata_i,
  input  logic                                  pix_vld_i,
  input  logic [PIXEL_BITS-1:0]                 pix_i,
  input  logic                                  bndl_rdy_i,
  output lpc_bndl_t                             bndl_o,
  output logic [ROW_W-1:0]                      row_o,
  output logic [COL_W-1:0]                      col_o,
  output logic [NUM_SLOTS-1:0][PIXEL_BITS-1:0]  vals_o
);

  localparam int unsigned WIDTH_RST_EFF = (MAX_WIDTH < WIDTH_RST) ? MAX_WIDTH : WIDTH_RST;
  localparam logic [COL_W-1:0] COL_LAST = COL_W'(MAX_WIDTH - 1);

  logic [WREG_W-1:0]     fw_q;
  logic [HEIGHT_W-1:0]   fh_q;
  logic [COL_W-1:0]      col_q, col_d;
  logic [ROW_W-1:0]      row_q, row_d;
  logic [PIXEL_BITS-1:0] ul_q, ul_d, llc_q, llc_d, llo_q, llo_d;
  logic                  fwd_a_q, fwd_b_q;
  logic [PIXEL_BITS-1:0] wr_pix_q, wr_corr_q;

  logic [WREG_W-1:0]       w_m1;
  logic [HEIGHT_W-1:0]     h_m1;
  logic                    last_col, last_row, acc;
  logic [COL_W-1:0]        raddr_a, raddr_b;
  logic [2*PIXEL_BITS-1:0] rd_oc;
  logic [PIXEL_BITS-1:0]   rd_a, rd_b, rd_c;
  logic [PIXEL_BITS-1:0]   orig_c, orig_n, corr_c, corr_wr;
  logic [PIXEL_BITS-1:0]   mx1, mx2, mx3, corr1, corr2, corr3;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q <= WREG_W'(WIDTH_RST_EFF);
      fh_q <= HEIGHT_W'(1);
    end else if (cfg_we_i) begin
      case (lpc_reg_e'(cfg_idx_i))
        REG_FRAME_WIDTH:  fw_q <= cfg_wdata_i[WREG_W-1:0];
        REG_FRAME_HEIGHT: fh_q <= cfg_wdata_i[HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective frame limits: zero means one, width saturates at the row memory depth
  always_comb begin
    if (fw_q == '0) begin
      w_m1 = '0;
    end else if (fw_q > WREG_W'(MAX_WIDTH)) begin
      w_m1 = WREG_W'(MAX_WIDTH - 1);
    end else begin
      w_m1 = fw_q - WREG_W'(1);
    end
    h_m1 = (fh_q == '0) ? '0 : fh_q - HEIGHT_W'(1);
  end

  assign last_col = {1'b0, col_q} >= w_m1;
  assign last_row = row_q >= h_m1;
  assign acc      = pix_vld_i && bndl_rdy_i;

  // Raster position of the next pixel
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (acc) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + ROW_W'(1);
      end else begin
        col_d = col_q + COL_W'(1);
      end
    end
  end

  // Reads are addressed at the next pixel's column, ahead of its arrival
  assign raddr_a = col_d;
  assign raddr_b = (col_d == COL_LAST) ? col_d : col_d + COL_W'(1);

  // Row 0 writes back the stored corrected value unchanged
  assign corr_wr = (row_q != '0) ? corr1 : corr_c;

  // Previous-row original and corrected value of each column, one word per column
  lpc_ram #(.WIDTH(2*PIXEL_BITS), .DEPTH(MAX_WIDTH)) u_row (
    .clk_i   (clk_i),
    .we_i    (acc),
    .waddr_i (col_q),
    .wdata_i ({corr_wr, pix_i}),
    .raddr_i (raddr_a),
    .rdata_o (rd_oc)
  );

  assign rd_a = rd_oc[PIXEL_BITS-1:0];
  assign rd_c = rd_oc[2*PIXEL_BITS-1:PIXEL_BITS];

  // Previous-row originals, read at the right-hand column
  lpc_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_WIDTH)) u_orig_b (
    .clk_i   (clk_i),
    .we_i    (acc),
    .waddr_i (col_q),
    .wdata_i (pix_i),
    .raddr_i (raddr_b),
    .rdata_o (rd_b)
  );

  // Forward a write that collided with the read issued on the same edge
  assign orig_c = fwd_a_q ? wr_pix_q  : rd_a;
  assign orig_n = fwd_b_q ? wr_pix_q  : rd_b;
  assign corr_c = fwd_a_q ? wr_corr_q : rd_c;

  // Neighbor maxima and clamps
  always_comb begin
    // pixel above: new pixel below, corrected above and left, original right
    mx1 = pix_i;
    if ((row_q > ROW_W'(1)) && (corr_c > mx1)) mx1 = corr_c;
    if ((col_q != '0) && (ul_q > mx1)) mx1 = ul_q;
    if (!last_col && (orig_n > mx1)) mx1 = orig_n;
    corr1 = (mx1 < orig_c) ? mx1 : orig_c;

    // last-row pixel to the left: corrected above (held in ul_q) and left, new pixel right
    mx2 = pix_i;
    if ((row_q != '0) && (ul_q > mx2)) mx2 = ul_q;
    if ((col_q > COL_W'(1)) && (llc_q > mx2)) mx2 = llc_q;
    corr2 = (mx2 < llo_q) ? mx2 : llo_q;

    // arriving pixel at the frame end: corrected above and left
    mx3 = '0;
    if (row_q != '0) mx3 = corr1;
    if ((col_q != '0) && (corr2 > mx3)) mx3 = corr2;
    corr3 = (((row_q != '0) || (col_q != '0)) && (mx3 < pix_i)) ? mx3 : pix_i;
  end

  // Left-neighbor state for the next pixel
  always_comb begin
    ul_d  = ul_q;
    llc_d = llc_q;
    llo_d = llo_q;
    if (acc) begin
      if (row_q != '0) ul_d = corr1;
      if (last_row) begin
        if (col_q != '0) llc_d = corr2;
        if (last_col) begin
          llc_d = corr3;
        end else begin
          llo_d = pix_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      ul_q    <= '0;
      llc_q   <= '0;
      llo_q   <= '0;
      fwd_a_q <= 1'b0;
      fwd_b_q <= 1'b0;
    end else begin
      col_q   <= col_d;
      row_q   <= row_d;
      ul_q    <= ul_d;
      llc_q   <= llc_d;
      llo_q   <= llo_d;
      fwd_a_q <= acc && (raddr_a == col_q);
      fwd_b_q <= acc && (raddr_b == col_q);
    end
  end

  // Write data kept for forwarding
  always_ff @(posedge clk_i) begin
    if (acc) begin
      wr_pix_q  <= pix_i;
      wr_corr_q <= corr_wr;
    end
  end

  // Results released by this pixel
  assign bndl_o.vld              = acc;
  assign bndl_o.slots[SLOT_UP]   = row_q != '0;
  assign bndl_o.slots[SLOT_LEFT] = last_row && (col_q != '0);
  assign bndl_o.slots[SLOT_SELF] = last_row && last_col;
  assign row_o                   = row_q;
  assign col_o                   = col_q;
  assign vals_o[SLOT_UP]         = corr1;
  assign vals_o[SLOT_LEFT]       = corr2;
  assign vals_o[SLOT_SELF]       = corr3;

endmodule

/* design/lpc_drain.sv */
`timescale 1ns / 1ps
// Result drain: holds the up-to-three results of one pixel and sends them
// one beat per cycle while out_rdy_i allows, through an output register. Depends on lpc_pkg.
module lpc_drain import lpc_pkg::*; #(
  parameter int unsigned PIXEL_BITS = PIXEL_BITS_DEF,
  parameter int unsigned COL_W      = 10
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  lpc_bndl_t                            bndl_i,
  input  logic [ROW_W-1:0]                     row_i,
  input  logic [COL_W-1:0]                     col_i,
  input  logic [NUM_SLOTS-1:0][PIXEL_BITS-1:0] vals_i,
  output logic                                 bndl_rdy_o,
  output logic                                 out_vld_o,
  input  logic                                 out_rdy_i,
  output logic [ROW_W-1:0]                     out_row_o,
  output logic [COL_W-1:0]                     out_col_o,
  output logic [PIXEL_BITS-1:0]                out_val_o,
  output logic                                 out_done_o,
  output logic                                 out_last_o
);

  logic [NUM_SLOTS-1:0]                 slots_q;
  logic [ROW_W-1:0]                     row_q;
  logic [COL_W-1:0]                     col_q;
  logic [NUM_SLOTS-1:0][PIXEL_BITS-1:0] vals_q;
  logic                                 out_vld_q;
  logic [ROW_W-1:0]                     out_row_q;
  logic [COL_W-1:0]                     out_col_q;
  logic [PIXEL_BITS-1:0]                out_val_q;
  logic                                 out_done_q, out_last_q;

  logic                  load;
  logic [NUM_SLOTS-1:0]  pick, rem;
  logic [ROW_W-1:0]      sel_row;
  logic [COL_W-1:0]      sel_col;
  logic [PIXEL_BITS-1:0] sel_val;

  // Lowest pending slot goes out first
  assign load = (!out_vld_q || out_rdy_i) && (slots_q != '0);
  assign pick = slots_q & ~(slots_q - NUM_SLOTS'(1));
  assign rem  = slots_q & ~pick;

  assign bndl_rdy_o = (slots_q == '0) || (load && (rem == '0));

  // Position tag of the picked slot
  always_comb begin
    sel_row = row_q;
    sel_col = col_q;
    sel_val = vals_q[SLOT_SELF];
    if (pick[SLOT_UP]) begin
      sel_row = row_q - ROW_W'(1);
      sel_val = vals_q[SLOT_UP];
    end else if (pick[SLOT_LEFT]) begin
      sel_col = col_q - COL_W'(1);
      sel_val = vals_q[SLOT_LEFT];
    end
  end

  // Pending slots and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slots_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (bndl_i.vld) begin
        slots_q <= bndl_i.slots;
      end else if (load) begin
        slots_q <= rem;
      end
      if (load) begin
        out_vld_q <= 1'b1;
      end else if (out_rdy_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (bndl_i.vld) begin
      row_q  <= row_i;
      col_q  <= col_i;
      vals_q <= vals_i;
    end
    if (load) begin
      out_row_q  <= sel_row;
      out_col_q  <= sel_col;
      out_val_q  <= sel_val;
      out_done_q <= pick[SLOT_SELF];
      out_last_q <= rem == '0;
    end
  end

  assign out_vld_o  = out_vld_q;
  assign out_row_o  = out_row_q;
  assign out_col_o  = out_col_q;
  assign out_val_o  = out_val_q;
  assign out_done_o = out_done_q;
  assign out_last_o = out_last_q;

endmodule

/* design/local_peak_clamp_filter.sv */
`timescale 1ns / 1ps
// Top level of the local peak clamp filter: kernel plus result drain.
// Depends on lpc_pkg, lpc_ifs, lpc_ram, lpc_kernel and lpc_drain.
//
//   port       dir  kind          beat
//   pix_in     in   valid/ready   one original pixel, raster order
//   res_out    out  valid/ready   one corrected pixel with row/col tag
//   cfg_*_i    in   write strobe  frame_width (0), frame_height (1)
//
// One pixel per clock while pix_in.ready is high; a pixel yields zero, one,
// two or three results and the output register sends one per clock while
// res_out.ready is high, so in the last row the output paces the input. Row
// memories are read ahead at the next column with same-column forwarding.
// No clearing pass after reset: the row memories are written before they are
// read. Output stalls back up via the three-slot result holder into pix_in.ready.
module local_peak_clamp_filter import lpc_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int unsigned PIXEL_BITS = PIXEL_BITS_DEF,
  localparam int unsigned COL_W     = $clog2(MAX_WIDTH),
  localparam int unsigned WREG_W    = COL_W + 1,
  localparam int unsigned CFG_W     = (WREG_W > HEIGHT_W) ? WREG_W : HEIGHT_W
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  lpc_pix_if.sink              pix_in,
  lpc_res_if.source            res_out
);

  lpc_bndl_t                            bndl;
  logic                                 bndl_rdy;
  logic [ROW_W-1:0]                     bndl_row;
  logic [COL_W-1:0]                     bndl_col;
  logic [NUM_SLOTS-1:0][PIXEL_BITS-1:0] bndl_vals;

  // Clamp kernel
  lpc_kernel #(.MAX_WIDTH(MAX_WIDTH), .PIXEL_BITS(PIXEL_BITS)) u_kernel (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .pix_vld_i   (pix_in.valid),
    .pix_i       (pix_in.pixel),
    .bndl_rdy_i  (bndl_rdy),
    .bndl_o      (bndl),
    .row_o       (bndl_row),
    .col_o       (bndl_col),
    .vals_o      (bndl_vals)
  );

  assign pix_in.ready = bndl_rdy;

  // Result drain
  lpc_drain #(.PIXEL_BITS(PIXEL_BITS), .COL_W(COL_W)) u_drain (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .bndl_i     (bndl),
    .row_i      (bndl_row),
    .col_i      (bndl_col),
    .vals_i     (bndl_vals),
    .bndl_rdy_o (bndl_rdy),
    .out_vld_o  (res_out.valid),
    .out_rdy_i  (res_out.ready),
    .out_row_o  (res_out.row_index),
    .out_col_o  (res_out.col_index),
    .out_val_o  (res_out.value),
    .out_done_o (res_out.frame_done),
    .out_last_o (res_out.step_last)
  );

  // The frame-end pixel is always the last result of its input beat
  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_out.valid && res_out.frame_done |-> res_out.step_last)
    else $error("frame_done beat without step_last");

  // Results of one input beat leave back to back
  a_step_unbroken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_out.valid && res_out.ready && !res_out.step_last |=> res_out.valid)
    else $error("gap inside the results of one input beat");

  // A pixel is taken only when the result holder can absorb its results
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bndl.vld |-> bndl_rdy)
    else $error("pixel accepted while result holder full");

endmodule
